/* rtl/core/fwt_pkg.sv */
// Shared constants, types and helpers for the Forth word tokenizer.
package fwt_pkg;

  localparam int MAX_WORD = 32;
  localparam int LEN_W    = $clog2(MAX_WORD + 1);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    MODE_SKIP,
    MODE_WORD,
    MODE_BRACE,
    MODE_PAREN,
    MODE_LINE,
    MODE_EMIT
  } mode_t;

  // Per-cell control: load the incoming character, or take the right neighbor's.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  // Controller to cell row.
  typedef struct packed {
    logic             load;
    logic             shift;
    logic [LEN_W-1:0] length;
  } chain_ctl_t;

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

/* rtl/core/forth_word_tokenizer.sv */
// Top level of the Forth word tokenizer: controller plus a row of character cells.
//
//   Channel  Direction  Payload                          Handshake
//   s_*      in         tdata = in_char                  s_tvalid / s_tready
//   m_*      out        tdata = word_char, tlast =       m_tvalid / m_tready
//                       word_last, tuser = word_truncated
//   cfg_*    in         cfg_wdata = skip_comments        cfg_we, no wait
//
// Input beats are taken one per cycle while a word is gathered or text is skipped.
// A word of L stored characters (L at most MAX_WORD) is then emitted as L beats,
// one beat per cycle while m_tready is high, by shifting the cell row toward cell 0,
// which drives m_tdata. s_tready is low for the whole emission, so no input is taken.
// A stalled output beat holds because the row shifts only on an accepted beat.
// rst is synchronous and clears the scan mode, word length, overflow flag and sets
// skip_comments; the character cells are not reset.
module forth_word_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,   // skip_comments
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,     // [7:0] in_char
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,     // [7:0] word_char
  output logic       m_tlast,     // word_last
  output logic       m_tuser      // [0] word_truncated
);

  fwt_pkg::chain_ctl_t chain;
  logic [7:0]          cell_q [fwt_pkg::MAX_WORD];

  // The controller decides when a character is written and when the row shifts.
  fwt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .in_char   (s_tdata),
    .head_char (cell_q[0]),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .chain     (chain)
  );

  // Each cell loads the incoming character when the word length points at it,
  // and during emission takes its right neighbor's character on every accepted output beat.
  for (genvar i = 0; i < fwt_pkg::MAX_WORD; i++) begin : g_cell
    fwt_pkg::cell_ctl_t ctl;
    logic [7:0]         next_char;

    assign ctl.load  = chain.load && (chain.length == fwt_pkg::LEN_W'(i));
    assign ctl.shift = chain.shift;

    if (i == fwt_pkg::MAX_WORD - 1) begin : g_end
      assign next_char = 8'h00;
    end else begin : g_mid
      assign next_char = cell_q[i+1];
    end

    fwt_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load_char (s_tdata),
      .next_char (next_char),
      .char_q    (cell_q[i])
    );
  end

  // Cell 0 is the head of the row and holds the character being offered.
  assign m_tdata = cell_q[0];

endmodule

/* rtl/core/fwt_cell.sv */
// One character cell of the word buffer row.
module fwt_cell (
  input  logic              clk,
  input  fwt_pkg::cell_ctl_t ctl,
  input  logic [7:0]        load_char,
  input  logic [7:0]        next_char,
  output logic [7:0]        char_q
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      char_q <= load_char;
    end else if (ctl.shift) begin
      char_q <= next_char;
    end
  end

endmodule

/* rtl/core/fwt_ctrl.sv */
// Scan-mode controller: word gathering, comment dropping and run emission.
module fwt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          in_char,
  input  logic [7:0]          head_char,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic                m_tlast,
  output logic                m_tuser,
  output fwt_pkg::chain_ctl_t chain
);

  fwt_pkg::mode_t            mode, mode_next;
  logic [fwt_pkg::LEN_W-1:0] length, length_next;
  logic                      overflow, overflow_next;
  logic                      skip_comments;
  logic                      acc;
  logic                      sep;
  logic                      single;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= fwt_pkg::MODE_SKIP;
      length        <= '0;
      overflow      <= 1'b0;
      skip_comments <= 1'b1;
    end else begin
      mode     <= mode_next;
      length   <= length_next;
      overflow <= overflow_next;
      if (cfg_we) begin
        skip_comments <= cfg_wdata;
      end
    end
  end

  assign s_tready = (mode != fwt_pkg::MODE_EMIT);
  assign acc      = s_tvalid && s_tready;
  assign sep      = fwt_pkg::is_sep(in_char);
  assign single   = skip_comments && (length == fwt_pkg::LEN_W'(1)) && !overflow;

  always_comb begin
    mode_next     = mode;
    length_next   = length;
    overflow_next = overflow;
    chain.length  = length;
    chain.load    = 1'b0;
    chain.shift   = 1'b0;
    m_tvalid      = 1'b0;
    m_tlast       = (length == fwt_pkg::LEN_W'(1));
    m_tuser       = overflow;
    case (mode)
      fwt_pkg::MODE_SKIP: begin
        if (acc && !sep) begin
          chain.load    = 1'b1;
          length_next   = fwt_pkg::LEN_W'(1);
          overflow_next = 1'b0;
          mode_next     = fwt_pkg::MODE_WORD;
        end
      end
      fwt_pkg::MODE_WORD: begin
        if (acc) begin
          if (!sep) begin
            if (length < fwt_pkg::LEN_W'(fwt_pkg::MAX_WORD)) begin
              chain.load  = 1'b1;
              length_next = length + fwt_pkg::LEN_W'(1);
            end else begin
              overflow_next = 1'b1;
            end
          end else if (single && head_char == fwt_pkg::CH_LBRACE) begin
            mode_next     = fwt_pkg::MODE_BRACE;
            length_next   = '0;
            overflow_next = 1'b0;
          end else if (single && head_char == fwt_pkg::CH_LPAREN) begin
            mode_next     = fwt_pkg::MODE_PAREN;
            length_next   = '0;
            overflow_next = 1'b0;
          end else if (single && head_char == fwt_pkg::CH_BSLASH) begin
            mode_next     = fwt_pkg::MODE_LINE;
            length_next   = '0;
            overflow_next = 1'b0;
          end else begin
            mode_next = fwt_pkg::MODE_EMIT;
          end
        end
      end
      fwt_pkg::MODE_BRACE: begin
        if (acc && in_char == fwt_pkg::CH_RBRACE) begin
          mode_next = fwt_pkg::MODE_SKIP;
        end
      end
      fwt_pkg::MODE_PAREN: begin
        if (acc && in_char == fwt_pkg::CH_RPAREN) begin
          mode_next = fwt_pkg::MODE_SKIP;
        end
      end
      fwt_pkg::MODE_LINE: begin
        if (acc && (in_char == fwt_pkg::CH_CR || in_char == fwt_pkg::CH_LF)) begin
          mode_next = fwt_pkg::MODE_SKIP;
        end
      end
      fwt_pkg::MODE_EMIT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          chain.shift = 1'b1;
          length_next = length - fwt_pkg::LEN_W'(1);
          if (length == fwt_pkg::LEN_W'(1)) begin
            mode_next     = fwt_pkg::MODE_SKIP;
            overflow_next = 1'b0;
          end
        end
      end
      default: begin
        mode_next   = fwt_pkg::MODE_SKIP;
        length_next = '0;
      end
    endcase
  end

endmodule

/* rtl/core/fwt_checker.sv */
// Port-level checker for the Forth word tokenizer, bound to the top level.
module fwt_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);

  // Input is never taken while a word is being emitted.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("s_tready high during word emission");

  // A run continues without gaps until its last beat.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("word run broken before its last beat");

  // The truncation flag is constant across one word.
  a_trunc_steady: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> $stable(m_tuser))
    else $error("word_truncated changed inside a word");

  // After the last beat the block returns to reading input.
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
    else $error("output still valid after last beat");

  // A stalled beat keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output beat changed");

endmodule

bind forth_word_tokenizer fwt_checker u_fwt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

/* test/forth_word_tokenizer_tb.sv */
// Self-checking testbench for the Forth word tokenizer: directed and random text streams.
module forth_word_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Each run goes well past the slowest legal one: every beat may wait out the
  // longest output stall and every character the longest input gap.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_CHARS = 290;
  localparam int SETTLE_CYCLES = 48;

  // One expected output beat of a finished word.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       trunc;
  } word_beat_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;     // [7:0] in_char
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;     // [7:0] word_char
  logic       m_tlast;     // word_last
  logic       m_tuser;     // [0] word_truncated

  forth_word_tokenizer u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Tokenizer shadow state, updated on every accepted character.
  fwt_pkg::mode_t scan_state;
  logic [7:0]     held_chars [fwt_pkg::MAX_WORD];
  int             held_len;
  logic           held_overflow;
  logic           skip_enable;

  word_beat_t word_beats [$];
  word_beat_t want_beat;

  int  errors;
  int  cycle_count;
  int  chars_sent;
  int  ready_hold;
  bit  idle_on;

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit is_blank(input logic [7:0] c);
    return c == fwt_pkg::CH_SPACE || c == fwt_pkg::CH_TAB ||
           c == fwt_pkg::CH_CR || c == fwt_pkg::CH_LF;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_blank(c));
    return c;
  endfunction

  task automatic clear_shadow();
    scan_state    = fwt_pkg::MODE_SKIP;
    held_len      = 0;
    held_overflow = 1'b0;
    skip_enable   = 1'b1;
  endtask

  // A separator has ended the word now held: either it opens a comment or
  // every stored character becomes one output beat.
  task automatic close_word();
    word_beat_t b;
    scan_state = fwt_pkg::MODE_SKIP;
    if (skip_enable && held_len == 1 && !held_overflow) begin
      if (held_chars[0] == fwt_pkg::CH_LBRACE) scan_state = fwt_pkg::MODE_BRACE;
      else if (held_chars[0] == fwt_pkg::CH_LPAREN) scan_state = fwt_pkg::MODE_PAREN;
      else if (held_chars[0] == fwt_pkg::CH_BSLASH) scan_state = fwt_pkg::MODE_LINE;
    end
    if (scan_state == fwt_pkg::MODE_SKIP) begin
      for (int i = 0; i < held_len; i++) begin
        b.ch    = held_chars[i];
        b.last  = (i == held_len - 1);
        b.trunc = held_overflow;
        word_beats.push_back(b);
      end
    end
    held_len      = 0;
    held_overflow = 1'b0;
  endtask

  // Advance the shadow tokenizer by one accepted character.
  task automatic tokenize_char(input logic [7:0] c);
    case (scan_state)
      fwt_pkg::MODE_BRACE: if (c == fwt_pkg::CH_RBRACE) scan_state = fwt_pkg::MODE_SKIP;
      fwt_pkg::MODE_PAREN: if (c == fwt_pkg::CH_RPAREN) scan_state = fwt_pkg::MODE_SKIP;
      fwt_pkg::MODE_LINE: begin
        if (c == fwt_pkg::CH_CR || c == fwt_pkg::CH_LF) scan_state = fwt_pkg::MODE_SKIP;
      end
      fwt_pkg::MODE_WORD: begin
        if (is_blank(c)) begin
          close_word();
        end else if (held_len < fwt_pkg::MAX_WORD) begin
          held_chars[held_len] = c;
          held_len++;
        end else begin
          held_overflow = 1'b1;
        end
      end
      default: begin
        if (!is_blank(c)) begin
          held_chars[0] = c;
          held_len      = 1;
          held_overflow = 1'b0;
          scan_state    = fwt_pkg::MODE_WORD;
        end
      end
    endcase
  endtask

  // Present one character and hold it until the block takes it. Valid stays
  // high between back-to-back beats and only drops when a gap is chosen.
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tokenize_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_char(txt[i]);
  endtask

  // Stop the input, wait for every predicted beat, then let the block run on for a
  // settling period so that a word still in flight would show up as extra beats.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (word_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_skip(input logic v);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    skip_enable = v;
  endtask

  // Receiver back-pressure: mostly ready, with short stalls and a few long ones.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      m_tready <= 1'b0;
      ready_hold--;
    end else if (idle_on && $urandom_range(0, 99) < 25) begin
      m_tready   <= 1'b0;
      ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Every accepted output beat is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (word_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: expected none, actual char %02h last %0b trunc %0b",
                 $realtime, m_tdata, m_tlast, m_tuser);
      end else begin
        want_beat = word_beats.pop_front();
        if (m_tdata !== want_beat.ch || m_tlast !== want_beat.last ||
            m_tuser !== want_beat.trunc) begin
          errors++;
          $display("%0t: beat mismatch: expected char %02h last %0b trunc %0b, actual %s",
                   $realtime, want_beat.ch, want_beat.last, want_beat.trunc,
                   $sformatf("char %02h last %0b trunc %0b", m_tdata, m_tlast, m_tuser));
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Separators of every kind, leading runs of them, and the byte extremes
  // inside words.
  task automatic test_word_split();
    send_text(" \t\r\n  ab");
    send_char(fwt_pkg::CH_TAB);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h7F);
    send_char(fwt_pkg::CH_CR);
    send_text("x\n");
    drain();
  endtask

  // All three comment forms, openers that are not whole words, and a word
  // that starts right after a closer.
  task automatic test_comment_skip();
    send_text("{ a } b ( c ) \\ d\re {x ");
    send_text("( q)z } ");
    drain();
  endtask

  // A word that just fits and two that overrun the store.
  task automatic test_overlong_word();
    for (int i = 0; i < fwt_pkg::MAX_WORD; i++) send_char(8'h41 + 8'(i % 26));
    send_char(fwt_pkg::CH_SPACE);
    for (int i = 0; i < fwt_pkg::MAX_WORD + 2; i++) send_char(8'h61 + 8'(i % 26));
    send_char(fwt_pkg::CH_LF);
    send_char(fwt_pkg::CH_LBRACE);
    for (int i = 0; i < fwt_pkg::MAX_WORD + 8; i++) send_char(fwt_pkg::CH_LBRACE);
    send_char(fwt_pkg::CH_SPACE);
    drain();
  endtask

  // With skipping off the openers come out as ordinary words.
  task automatic test_skip_disabled();
    set_skip(1'b0);
    send_text("{ ( \\ } ");
    set_skip(1'b1);
    drain();
  endtask

  // A comment that is already open runs to its closer whatever the register says.
  task automatic test_toggle_in_comment();
    send_text("( a ");
    set_skip(1'b0);
    send_text("b ) c ");
    set_skip(1'b1);
    send_text("\\ ");
    set_skip(1'b0);
    send_text("y\nw ");
    set_skip(1'b1);
  endtask

  // Mostly well-formed text: words of random content, comments with random
  // bodies, and some raw noise, with idle phases and register changes.
  task automatic test_random_text();
    int start;
    int r;
    int n;
    int kind;
    logic [7:0] c;
    start = chars_sent;
    while (chars_sent - start < RANDOM_CHARS) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        r = $urandom_range(0, 99);
        n = (r < 85) ? $urandom_range(1, 8) :
            (r < 95) ? $urandom_range(9, fwt_pkg::MAX_WORD - 1) :
                       $urandom_range(fwt_pkg::MAX_WORD, fwt_pkg::MAX_WORD + 12);
        repeat (n) send_char(rand_word_char());
        n = $urandom_range(1, 3);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: send_char(fwt_pkg::CH_SPACE);
            1: send_char(fwt_pkg::CH_TAB);
            2: send_char(fwt_pkg::CH_CR);
            default: send_char(fwt_pkg::CH_LF);
          endcase
        end
      end else if (r < 78) begin
        kind = $urandom_range(0, 2);
        send_char(kind == 0 ? fwt_pkg::CH_LBRACE :
                  kind == 1 ? fwt_pkg::CH_LPAREN : fwt_pkg::CH_BSLASH);
        send_char($urandom_range(0, 1) ? fwt_pkg::CH_SPACE : fwt_pkg::CH_LF);
        n = $urandom_range(0, 10);
        repeat (n) begin
          c = 8'($urandom_range(0, 255));
          if (kind == 0 && c == fwt_pkg::CH_RBRACE) c = fwt_pkg::CH_SPACE;
          if (kind == 1 && c == fwt_pkg::CH_RPAREN) c = fwt_pkg::CH_SPACE;
          if (kind == 2 && (c == fwt_pkg::CH_CR || c == fwt_pkg::CH_LF)) c = fwt_pkg::CH_TAB;
          send_char(c);
        end
        if (kind == 0) send_char(fwt_pkg::CH_RBRACE);
        else if (kind == 1) send_char(fwt_pkg::CH_RPAREN);
        else send_char($urandom_range(0, 1) ? fwt_pkg::CH_CR : fwt_pkg::CH_LF);
      end else if (r < 94) begin
        n = $urandom_range(1, 6);
        repeat (n) send_char(8'($urandom_range(0, 255)));
      end else begin
        idle_on = $urandom_range(0, 2) != 0;
        set_skip(1'($urandom_range(0, 1)));
      end
    end
    idle_on = 1'b1;
    send_char(fwt_pkg::CH_SPACE);
  endtask

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_wdata   = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = 8'h00;
    m_tready    = 1'b0;
    errors      = 0;
    cycle_count = 0;
    chars_sent  = 0;
    ready_hold  = 0;
    idle_on     = 1'b1;
    clear_shadow();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_word_split();
    test_comment_skip();
    test_overlong_word();
    test_skip_disabled();
    test_toggle_in_comment();
    test_random_text();
    drain();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
